FILE: sv/wtfg_pkg.sv
// Shared types and constants for the wiggle trace fill generator.
package wtfg_pkg;

  // Sample format and sample counter widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned TIME_W   = INDEX_W + FRAC_W;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned OVL_W    = 3;
  localparam int unsigned CFG_W    = 3;

  // Default trace length limit.
  localparam int unsigned MAX_SAMPLES_DEF = 4096;

  // Threshold used when fill is enabled: 0.001 rounded to Q3.12.
  localparam logic signed [SAMPLE_W-1:0] FILL_THRESH = 16'sd4;

  // Configuration register indexes.
  localparam logic CFG_FILL_ENABLE = 1'b0;
  localparam logic CFG_OVERLAP     = 1'b1;

  // Pen command codes.
  localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAW    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ABANDON = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;
    logic out_free;
    logic one_left;
  } ctl_sts_t;

endpackage

FILE: sv/wiggle_trace_fill_generator_core.sv
// A sample is taken in the idle state and passes through the divide state, where
// the 12-step serial divider runs only when a threshold crossing needs it. Its 1 to 5
// result words are then registered one at a time while the output register is free,
// and no new sample is taken until the last of them is emitted.
// Reset (synchronous, rst_n low) clears the trace state, the pending results and
// the output valid flag, and sets fill enable to 1 and overlap to 2.
module wiggle_trace_fill_generator_core #(
  parameter int unsigned MAX_SAMPLES = wtfg_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [wtfg_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [wtfg_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  in_trace_end,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [wtfg_pkg::KIND_W-1:0]           out_kind,
  output logic signed [wtfg_pkg::SAMPLE_W-1:0]  out_amplitude,
  output logic [wtfg_pkg::TIME_W-1:0]           out_time_pos,
  output logic                                  out_poly_end,
  output logic                                  out_last_result
);

  wtfg_pkg::ctl_cmd_t cmd;
  wtfg_pkg::ctl_sts_t sts;

  // Sequencing of accept, divide and emit.
  wtfg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Trace state, divider and result register.
  wtfg_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_sample       (in_sample),
    .in_trace_end    (in_trace_end),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_amplitude   (out_amplitude),
    .out_time_pos    (out_time_pos),
    .out_poly_end    (out_poly_end),
    .out_last_result (out_last_result),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: sv/wtfg_ctrl.sv
// Controller state machine: accept, divide and emit sequencing.
module wtfg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wtfg_pkg::ctl_sts_t sts,
  output wtfg_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int unsigned DIV_STEPS = wtfg_pkg::FRAC_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Input words are taken only while no item is in progress.
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Skip the divider when no crossing point is needed.
        if (!sts.need_div) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.div_step = 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.one_left) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // A result word is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register busy");

  // The divide counter stays within the step count.
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divide counter out of range");
`endif

endmodule

FILE: sv/wtfg_dpath.sv
// Datapath: trace state, result list, crossing divider and output register.
module wtfg_dpath #(
  parameter int unsigned MAX_SAMPLES = wtfg_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [wtfg_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic signed [wtfg_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  in_trace_end,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [wtfg_pkg::KIND_W-1:0]           out_kind,
  output logic signed [wtfg_pkg::SAMPLE_W-1:0]  out_amplitude,
  output logic [wtfg_pkg::TIME_W-1:0]           out_time_pos,
  output logic                                  out_poly_end,
  output logic                                  out_last_result,
  input  wtfg_pkg::ctl_cmd_t                    cmd,
  output wtfg_pkg::ctl_sts_t                    sts
);

  localparam int unsigned SW = wtfg_pkg::SAMPLE_W;
  localparam int unsigned IW = wtfg_pkg::INDEX_W;
  localparam int unsigned FW = wtfg_pkg::FRAC_W;
  localparam int unsigned TW = wtfg_pkg::TIME_W;
  localparam int unsigned KW = wtfg_pkg::KIND_W;
  localparam int unsigned OW = wtfg_pkg::OVL_W;
  localparam int unsigned NSLOT = 9;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SAMPLES - 1);

  // Result slots in emission order.
  localparam int unsigned SL_MOVE    = 0;
  localparam int unsigned SL_DRAW    = 1;
  localparam int unsigned SL_START_S = 2;
  localparam int unsigned SL_START_P = 3;
  localparam int unsigned SL_ABANDON = 4;
  localparam int unsigned SL_RISE    = 5;
  localparam int unsigned SL_SAMPLE  = 6;
  localparam int unsigned SL_FALL    = 7;
  localparam int unsigned SL_CLOSE   = 8;

  // Configuration and trace state.
  logic                 fill_en_r;
  logic [OW-1:0]        overlap_r;
  logic signed [SW-1:0] prev_r, prev_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 open_r, open_nxt;

  // Per-item working registers.
  logic signed [SW-1:0] d_r, p_r, thr_r;
  logic [IW-1:0]        item_idx_r;
  logic [NSLOT-1:0]     mask_r, mask_nxt;
  logic [SW-1:0]        rem_r, ud_r;
  logic [FW-1:0]        q_r;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [KW-1:0]        out_kind_r, kind_nxt;
  logic signed [SW-1:0] out_amp_r, amp_nxt;
  logic [TW-1:0]        out_time_r, time_nxt;
  logic                 out_pend_r, pend_nxt;
  logic                 out_last_r;

  logic signed [SW-1:0] thr;
  logic                 first, last, gt_d, lt_d, gt_p, start, rise, fall;
  logic signed [SW:0]   diff_n, diff_d;
  logic [SW-1:0]        un, ud;
  logic [SW:0]          rem_sh;
  logic [NSLOT-1:0]     lowest;
  logic [TW-1:0]        t_cross, t_here;

  // Threshold from the configuration.
  assign thr = fill_en_r ? wtfg_pkg::FILL_THRESH
                         : SW'(signed'({1'b0, overlap_r, {FW{1'b0}}}));

  // Classify the incoming sample against the previous one.
  assign first = (idx_r == '0);
  assign last  = in_trace_end || (idx_r >= LAST_IDX);
  assign gt_d  = (in_sample > thr);
  assign lt_d  = (in_sample < thr);
  assign gt_p  = (prev_r > thr);
  assign start = !first && (idx_r == IW'(1)) && gt_p && gt_d;
  assign rise  = !first && gt_d && !gt_p;
  assign fall  = !first && lt_d && gt_p;

  // Build the list of results this sample causes.
  always_comb begin
    mask_nxt             = '0;
    mask_nxt[SL_MOVE]    = first;
    mask_nxt[SL_DRAW]    = !first;
    mask_nxt[SL_START_S] = start;
    mask_nxt[SL_START_P] = start;
    mask_nxt[SL_ABANDON] = rise && open_r;
    mask_nxt[SL_RISE]    = rise;
    mask_nxt[SL_SAMPLE]  = !first && gt_d;
    mask_nxt[SL_FALL]    = fall && open_r;
    mask_nxt[SL_CLOSE]   = !first && !fall && last && (open_r || start || rise);
  end

  // Next trace state.
  always_comb begin
    prev_nxt = in_sample;
    if (first) begin
      open_nxt = 1'b0;
      idx_nxt  = in_trace_end ? '0 : IW'(1);
    end else if (last) begin
      open_nxt = 1'b0;
      idx_nxt  = '0;
    end else begin
      open_nxt = fall ? 1'b0 : (open_r || start || rise);
      idx_nxt  = idx_r + 1'b1;
    end
  end

  // Crossing operands: distance to threshold over distance between samples.
  assign diff_n = {thr[SW-1], thr} - {prev_r[SW-1], prev_r};
  assign diff_d = {in_sample[SW-1], in_sample} - {prev_r[SW-1], prev_r};
  assign un     = diff_n[SW] ? SW'(-diff_n) : diff_n[SW-1:0];
  assign ud     = diff_d[SW] ? SW'(-diff_d) : diff_d[SW-1:0];

  // One restoring divide step per cycle.
  assign rem_sh = {rem_r, 1'b0};

  // Pick the next result slot.
  assign lowest       = mask_r & (~mask_r + 1'b1);
  assign t_cross      = {item_idx_r - 1'b1, q_r};
  assign t_here       = {item_idx_r, {FW{1'b0}}};
  assign sts.need_div = mask_r[SL_RISE] || mask_r[SL_FALL];
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.one_left = ((mask_r & (mask_r - 1'b1)) == '0);

  always_comb begin
    kind_nxt = wtfg_pkg::KIND_FILL;
    amp_nxt  = thr_r;
    time_nxt = t_here;
    pend_nxt = 1'b0;
    case (1'b1)
      mask_r[SL_MOVE]: begin
        kind_nxt = wtfg_pkg::KIND_MOVE;
        amp_nxt  = d_r;
        time_nxt = '0;
      end
      mask_r[SL_DRAW]: begin
        kind_nxt = wtfg_pkg::KIND_DRAW;
        amp_nxt  = d_r;
      end
      mask_r[SL_START_S]: begin
        time_nxt = '0;
      end
      mask_r[SL_START_P]: begin
        amp_nxt  = p_r;
        time_nxt = '0;
      end
      mask_r[SL_ABANDON]: begin
        kind_nxt = wtfg_pkg::KIND_ABANDON;
        amp_nxt  = '0;
        time_nxt = '0;
      end
      mask_r[SL_RISE]: begin
        time_nxt = t_cross;
      end
      mask_r[SL_SAMPLE]: begin
        amp_nxt = d_r;
      end
      mask_r[SL_FALL]: begin
        time_nxt = t_cross;
        pend_nxt = 1'b1;
      end
      mask_r[SL_CLOSE]: begin
        pend_nxt = 1'b1;
      end
      default: begin
        kind_nxt = wtfg_pkg::KIND_FILL;
      end
    endcase
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_en_r   <= 1'b1;
      overlap_r   <= OW'(2);
      prev_r      <= '0;
      idx_r       <= '0;
      open_r      <= 1'b0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wtfg_pkg::CFG_FILL_ENABLE: fill_en_r <= cfg_wdata[0];
          wtfg_pkg::CFG_OVERLAP:     overlap_r <= cfg_wdata[OW-1:0];
          default:                   overlap_r <= overlap_r;
        endcase
      end
      if (cmd.load) begin
        prev_r <= prev_nxt;
        idx_r  <= idx_nxt;
        open_r <= open_nxt;
        mask_r <= mask_nxt;
      end else if (cmd.emit) begin
        mask_r <= mask_r & ~lowest;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r        <= in_sample;
      p_r        <= prev_r;
      thr_r      <= thr;
      item_idx_r <= idx_r;
      rem_r      <= un;
      ud_r       <= ud;
      q_r        <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, ud_r}) begin
        rem_r <= SW'(rem_sh - {1'b0, ud_r});
        q_r   <= {q_r[FW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[SW-1:0];
        q_r   <= {q_r[FW-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      out_kind_r <= kind_nxt;
      out_amp_r  <= amp_nxt;
      out_time_r <= time_nxt;
      out_pend_r <= pend_nxt;
      out_last_r <= sts.one_left;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_amplitude   = out_amp_r;
  assign out_time_pos    = out_time_r;
  assign out_poly_end    = out_pend_r;
  assign out_last_result = out_last_r;

`ifndef SYNTHESIS
  // The crossing fraction is below one, so the partial remainder starts below the divisor.
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (!(mask_r[SL_RISE] || mask_r[SL_FALL]) || (rem_r < ud_r)))
    else $error("crossing numerator not below divisor");

  // The word flagged as last leaves no pending result behind.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.one_left) |=> (mask_r == '0))
    else $error("results pending after last word");
`endif

endmodule
